// ===== design/tfbh_pkg.sv =====
// Package: widths, face table and shared types for the barycentric hit block.
`default_nettype none
package tfbh_pkg;
	localparam int COORD_BITS  = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS   = 2 * DIFF_BITS;
	localparam int NUM_BITS    = PROD_BITS + 1;
	localparam int DIV_STEPS   = WEIGHT_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [NUM_BITS-1:0]   num_t;
	typedef logic [WEIGHT_BITS-1:0]       weight_t;

	typedef struct packed {
		logic [15:0] tet_id;
		coord_t f0; coord_t g0;
		coord_t f1; coord_t g1;
		coord_t f2; coord_t g2;
		coord_t f3; coord_t g3;
	} tet_t;

	typedef struct packed {
		logic [15:0] tet_id;
		logic [1:0]  face;
		logic        hit;
		weight_t     alpha;
		weight_t     beta;
		logic        any_hit;
		logic        last;
	} res_t;

	// vertex selection per face: face 0=(0,1,2) 1=(0,1,3) 2=(0,2,3) 3=(1,2,3)
	function automatic logic [5:0] face_verts(input logic [1:0] k);
		logic [5:0] r;
		case (k)
			2'd0: r = {2'd0, 2'd1, 2'd2};
			2'd1: r = {2'd0, 2'd1, 2'd3};
			2'd2: r = {2'd0, 2'd2, 2'd3};
			default: r = {2'd1, 2'd2, 2'd3};
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== design/tfbh_if.sv =====
// Valid/ready channel interfaces for tetrahedra in and face results out.
`default_nettype none
interface tfbh_tet_if;
	logic        valid;
	logic        ready;
	logic [15:0] tet_id;
	logic [15:0] vert0_f, vert0_g, vert1_f, vert1_g;
	logic [15:0] vert2_f, vert2_g, vert3_f, vert3_g;
	modport source (output valid, tet_id, vert0_f, vert0_g, vert1_f, vert1_g,
		vert2_f, vert2_g, vert3_f, vert3_g, input ready);
	modport sink (input valid, tet_id, vert0_f, vert0_g, vert1_f, vert1_g,
		vert2_f, vert2_g, vert3_f, vert3_g, output ready);
endinterface

interface tfbh_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_tet_id;
	logic [1:0]  face_index;
	logic        inside_res;
	logic [15:0] alpha;
	logic [15:0] beta;
	logic        tet_has_hit;
	logic        last;
	modport source (output valid, out_tet_id, face_index, inside_res, alpha, beta,
		tet_has_hit, last, input ready);
	modport sink (input valid, out_tet_id, face_index, inside_res, alpha, beta,
		tet_has_hit, last, output ready);
endinterface
`default_nettype wire

// ===== design/tfbh_face_seq.sv =====
// Holds one tetrahedron and issues its four faces, one per cycle while adv is high.
`default_nettype none
module tfbh_face_seq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tfbh_pkg::tet_t in_tet,
	input  wire logic           adv,
	output logic                f_valid,
	output logic [1:0]          f_face,
	output tfbh_pkg::tet_t      f_tet
);
	logic          busy_q;
	logic [1:0]    face_q;
	tfbh_pkg::tet_t tet_q;

	assign f_valid  = busy_q;
	assign f_face   = face_q;
	assign f_tet    = tet_q;
	// a new tetrahedron loads as the fourth face leaves
	assign in_ready = !busy_q || (adv && face_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			face_q <= 2'd0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			face_q <= 2'd0;
		end else if (busy_q && adv) begin
			face_q <= face_q + 2'd1;
			if (face_q == 2'd3) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) tet_q <= in_tet;
	end
endmodule
`default_nettype wire

// ===== design/tfbh_div.sv =====
// Pipelined restoring divider: floor(num * 2^WEIGHT_BITS / den), one bit a stage.
`default_nettype none
module tfbh_div (
	input  wire logic                         clk,
	input  wire logic                         adv,
	input  wire logic [tfbh_pkg::NUM_BITS-1:0] num,
	input  wire logic [tfbh_pkg::NUM_BITS-1:0] den,
	output tfbh_pkg::weight_t                 quo
);
	localparam int N = tfbh_pkg::DIV_STEPS;
	localparam int W = tfbh_pkg::NUM_BITS + 1;

	logic [W-1:0]      rem_s [1:N-1];
	logic [W-1:0]      den_s [1:N-1];
	tfbh_pkg::weight_t q_s   [1:N];

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [W-1:0]      r_in, d_in, sh;
		tfbh_pkg::weight_t q_in;
		logic              ge;
		if (i == 0) begin : g_first
			assign r_in = {1'b0, num};
			assign d_in = {1'b0, den};
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[i];
			assign d_in = den_s[i];
			assign q_in = q_s[i];
		end
		assign sh = {r_in[W-2:0], 1'b0};
		assign ge = sh >= d_in;
		always_ff @(posedge clk) begin
			if (adv) q_s[i+1] <= {q_in[tfbh_pkg::WEIGHT_BITS-2:0], ge};
		end
		if (i < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[i+1] <= ge ? sh - d_in : sh;
					den_s[i+1] <= d_in;
				end
			end
		end
	end

	assign quo = q_s[N];
endmodule
`default_nettype wire

// ===== design/tfbh_face_calc.sv =====
// Face determinant and barycentric numerators: registered differences, products, numerators and normalize/test.
`default_nettype none
module tfbh_face_calc (
	input  wire logic                 clk,
	input  wire logic                 adv,
	input  wire logic [1:0]           face,
	input  wire tfbh_pkg::tet_t       tet,
	input  wire tfbh_pkg::coord_t     qu,
	input  wire tfbh_pkg::coord_t     qv,
	output logic                      hit,
	output logic [tfbh_pkg::NUM_BITS-1:0] na_out,
	output logic [tfbh_pkg::NUM_BITS-1:0] nb_out,
	output logic [tfbh_pkg::NUM_BITS-1:0] det_out
);
	tfbh_pkg::coord_t fa, ga, fb, gb, fc, gc;
	logic [5:0] vs;
	tfbh_pkg::coord_t fv [4];
	tfbh_pkg::coord_t gv [4];

	assign vs = tfbh_pkg::face_verts(face);
	assign fv[0] = tet.f0; assign gv[0] = tet.g0;
	assign fv[1] = tet.f1; assign gv[1] = tet.g1;
	assign fv[2] = tet.f2; assign gv[2] = tet.g2;
	assign fv[3] = tet.f3; assign gv[3] = tet.g3;
	assign fa = fv[vs[5:4]]; assign ga = gv[vs[5:4]];
	assign fb = fv[vs[3:2]]; assign gb = gv[vs[3:2]];
	assign fc = fv[vs[1:0]]; assign gc = gv[vs[1:0]];

	// stage 1: differences
	tfbh_pkg::diff_t x13_s1, y23_s1, x23_s1, y13_s1, du_s1, dv_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			x13_s1 <= tfbh_pkg::diff_t'(fa) - tfbh_pkg::diff_t'(fc);
			y23_s1 <= tfbh_pkg::diff_t'(gb) - tfbh_pkg::diff_t'(gc);
			x23_s1 <= tfbh_pkg::diff_t'(fb) - tfbh_pkg::diff_t'(fc);
			y13_s1 <= tfbh_pkg::diff_t'(ga) - tfbh_pkg::diff_t'(gc);
			du_s1  <= tfbh_pkg::diff_t'(qu) - tfbh_pkg::diff_t'(fc);
			dv_s1  <= tfbh_pkg::diff_t'(qv) - tfbh_pkg::diff_t'(gc);
		end
	end

	// stage 2: six products
	tfbh_pkg::prod_t p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s2 <= x13_s1 * y23_s1;
			p1_s2 <= x23_s1 * y13_s1;
			p2_s2 <= y23_s1 * du_s1;
			p3_s2 <= x23_s1 * dv_s1;
			p4_s2 <= y13_s1 * du_s1;
			p5_s2 <= x13_s1 * dv_s1;
		end
	end

	// stage 3: signed det and numerators
	tfbh_pkg::num_t det_s3, na_s3, nb_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s3 <= tfbh_pkg::num_t'(p0_s2) - tfbh_pkg::num_t'(p1_s2);
			na_s3  <= tfbh_pkg::num_t'(p2_s2) - tfbh_pkg::num_t'(p3_s2);
			nb_s3  <= tfbh_pkg::num_t'(p5_s2) - tfbh_pkg::num_t'(p4_s2);
		end
	end

	// stage 4: sign normalize, then the strict range test
	tfbh_pkg::num_t d_n, a_n, b_n, g_n;
	logic h_c;
	always_comb begin
		d_n = det_s3[tfbh_pkg::NUM_BITS-1] ? -det_s3 : det_s3;
		a_n = det_s3[tfbh_pkg::NUM_BITS-1] ? -na_s3 : na_s3;
		b_n = det_s3[tfbh_pkg::NUM_BITS-1] ? -nb_s3 : nb_s3;
		g_n = d_n - a_n - b_n;
		h_c = (a_n > 0) && (b_n > 0) && (g_n > 0) && (a_n < d_n) && (b_n < d_n)
			&& (g_n < d_n);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit     <= h_c;
			na_out  <= a_n;
			nb_out  <= b_n;
			det_out <= d_n;
		end
	end
endmodule
`default_nettype wire

// ===== design/tet_face_barycentric_hit_top.sv =====
// Top level: tetrahedron face hit test with configured query point.
`default_nettype none
// Usage:
//  tet  : sink channel, one tetrahedron per item (id plus four Q8.8 vertices).
//  res  : source channel, four face results per tetrahedron in face order
//         (0,1,2),(0,1,3),(0,2,3),(1,2,3); last marks the fourth.
//  cfg  : cfg_we/cfg_index/cfg_data write query_u (0) and query_v (1);
//         cfg_index is a single bit. Write only while the block is idle.
// Issue: one face per cycle while the pipeline advances; a new tetrahedron
//  loads as the previous fourth face issues.
// Pipeline: an issue register, 4 arithmetic stages (differences, products,
//  numerators, normalize/test), 16 divider stages, 1 output stage.
// Stall: the whole pipeline advances as one; with the output register full
//  and res.ready low, every stage holds, so nothing is lost or repeated.
// Reset: arst_n clears valid bits and the query point to zero.
module tet_face_barycentric_hit_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	tfbh_tet_if.sink         tet,
	tfbh_res_if.source       res
);
	localparam int DEPTH = 4 + tfbh_pkg::DIV_STEPS;
	localparam logic REG_U = 1'b0;
	localparam logic REG_V = 1'b1;

	tfbh_pkg::coord_t qu_q, qv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qu_q <= '0;
			qv_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_U: qu_q <= cfg_data;
				REG_V: qv_q <= cfg_data;
			endcase
		end
	end

	logic adv;
	assign adv = !res.valid || res.ready;

	tfbh_pkg::tet_t in_tet, f_tet;
	logic f_valid;
	logic [1:0] f_face;
	assign in_tet = '{tet.tet_id, tet.vert0_f, tet.vert0_g, tet.vert1_f, tet.vert1_g,
		tet.vert2_f, tet.vert2_g, tet.vert3_f, tet.vert3_g};

	tfbh_face_seq u_seq (.clk, .arst_n, .in_valid(tet.valid), .in_ready(tet.ready),
		.in_tet, .adv, .f_valid, .f_face, .f_tet);

	logic hit_c;
	logic [tfbh_pkg::NUM_BITS-1:0] na_c, nb_c, det_c;
	tfbh_face_calc u_calc (.clk, .adv, .face(f_face), .tet(f_tet), .qu(qu_q), .qv(qv_q),
		.hit(hit_c), .na_out(na_c), .nb_out(nb_c), .det_out(det_c));

	tfbh_pkg::weight_t qa, qb;
	tfbh_div u_div_a (.clk, .adv, .num(na_c), .den(det_c), .quo(qa));
	tfbh_div u_div_b (.clk, .adv, .num(nb_c), .den(det_c), .quo(qb));

	// side info travels alongside arithmetic: valid, id, face
	logic        v_s   [1:DEPTH];
	logic [15:0] id_s  [1:DEPTH];
	logic [1:0]  fc_s  [1:DEPTH];
	logic        hit_s [1:tfbh_pkg::DIV_STEPS];
	for (genvar i = 0; i < DEPTH; i++) begin : g_side
		logic        v_in;
		logic [15:0] id_in;
		logic [1:0]  fc_in;
		if (i == 0) begin : g_head
			assign v_in  = f_valid;
			assign id_in = f_tet.tet_id;
			assign fc_in = f_face;
		end else begin : g_body
			assign v_in  = v_s[i];
			assign id_in = id_s[i];
			assign fc_in = fc_s[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (adv) v_s[i+1] <= v_in;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				id_s[i+1] <= id_in;
				fc_s[i+1] <= fc_in;
			end
		end
	end
	for (genvar j = 0; j < tfbh_pkg::DIV_STEPS; j++) begin : g_hit
		logic h_in;
		if (j == 0) begin : g_head
			assign h_in = hit_c;
		end else begin : g_body
			assign h_in = hit_s[j];
		end
		always_ff @(posedge clk) begin
			if (adv) hit_s[j+1] <= h_in;
		end
	end

	// output register and running any-hit across one tetrahedron
	logic any_q;
	logic hit_e;
	logic [1:0] face_e;
	assign hit_e  = hit_s[tfbh_pkg::DIV_STEPS];
	assign face_e = fc_s[DEPTH];

	tfbh_pkg::res_t res_q;
	logic           rv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q  <= 1'b0;
			any_q <= 1'b0;
		end else if (adv) begin
			rv_q <= v_s[DEPTH];
			if (v_s[DEPTH]) any_q <= (face_e == 2'd3) ? 1'b0 : (any_q | hit_e);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.tet_id  <= id_s[DEPTH];
			res_q.face    <= face_e;
			res_q.hit     <= hit_e;
			res_q.alpha   <= hit_e ? qa : '0;
			res_q.beta    <= hit_e ? qb : '0;
			res_q.any_hit <= (face_e == 2'd3) && (any_q | hit_e);
			res_q.last    <= face_e == 2'd3;
		end
	end

	assign res.valid       = rv_q;
	assign res.out_tet_id  = res_q.tet_id;
	assign res.face_index  = res_q.face;
	assign res.inside_res  = res_q.hit;
	assign res.alpha       = res_q.alpha;
	assign res.beta        = res_q.beta;
	assign res.tet_has_hit = res_q.any_hit;
	assign res.last        = res_q.last;
endmodule
`default_nettype wire
